FILE: rtl/rcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // width of the external data path; hit_distance caps at 2^(DATA_WIDTH-1)-1
    localparam int DATA_WIDTH = 32;

    // input queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [2:0] CFG_BASE_X = 3'd0;
    localparam logic [2:0] CFG_BASE_Y = 3'd1;
    localparam logic [2:0] CFG_BASE_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS = 3'd3;
    localparam logic [2:0] CFG_HEIGHT = 3'd4;

    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [30:0]        radius;
        logic [30:0]        height;
    } t_cfg;

    // one classified ray as it waits in the queue
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [32:0] rel_x;
        logic signed [33:0] rel_y;
        logic signed [32:0] rel_z;
        logic signed [32:0] base_dy;
        logic               dy_nz;
    } t_item;

    function automatic logic signed [63:0] qsat(input logic signed [65:0] v);
        logic signed [65:0] hi;
        hi = 66'(SMAX);
        if (v > hi) begin
            return SMAX;
        end
        if (v < -hi) begin
            return -SMAX;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return qsat(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return qsat(66'(a) - 66'(b));
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rcc_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_qmul import rcc_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic signed [63:0]  i_a,
    input  wire logic signed [63:0]  i_b,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic signed [63:0]       o_p,
    output logic [SIDE_W-1:0]        o_side
);

    logic [63:0]        r_ma, r_mb;
    logic [63:0]        r_p00, r_p01, r_p10, r_p11;
    logic [1:0]         r_neg;
    logic [1:0]         r_vld;
    logic [SIDE_W-1:0]  r_side1, r_side2;
    logic [127:0]       w_sum;
    logic [127:0]       w_sh;
    logic [63:0]        w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[0], i_valid};
            o_valid <= r_vld[1];
        end
    end

    // magnitudes, then 32x32 partial products, then sum and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma     <= mag64(i_a);
            r_mb     <= mag64(i_b);
            r_neg[0] <= i_a[63] ^ i_b[63];
            r_side1  <= i_side;
            r_p00    <= r_ma[31:0]  * r_mb[31:0];
            r_p01    <= r_ma[31:0]  * r_mb[63:32];
            r_p10    <= r_ma[63:32] * r_mb[31:0];
            r_p11    <= r_ma[63:32] * r_mb[63:32];
            r_neg[1] <= r_neg[0];
            r_side2  <= r_side1;
            o_p      <= r_neg[1] ? 64'(-w_mag) : 64'(w_mag);
            o_side   <= r_side2;
        end
    end

    assign w_sum = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                 + {64'd0, r_p00};
    assign w_sh  = w_sum >> FRAC_BITS;
    assign w_mag = (|w_sh[127:63]) ? 64'(SMAX) : w_sh[63:0];

endmodule

`default_nettype wire

FILE: rtl/rcc_qdiv.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_qdiv import rcc_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic signed [63:0]  i_a,
    input  wire logic signed [63:0]  i_b,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic signed [63:0]       o_q,
    output logic [SIDE_W-1:0]        o_side
);

    // one quotient bit per stage over the dividend |a| << FRAC_BITS
    localparam int NB = 64 + FRAC_BITS;

    logic [NB-1:0]      r_num  [NB+1];
    logic [NB-1:0]      r_quo  [NB+1];
    logic [63:0]        r_rem  [NB+1];
    logic [63:0]        r_den  [NB+1];
    logic               r_neg  [NB+1];
    logic               r_vld  [NB+1];
    logic [SIDE_W-1:0]  r_side [NB+1];
    logic [63:0]        w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            o_valid  <= r_vld[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= {mag64(i_a), {FRAC_BITS{1'b0}}};
            r_den[0]  <= mag64(i_b);
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
            r_neg[0]  <= i_a[63] ^ i_b[63];
            r_side[0] <= i_side;
            o_q       <= r_neg[NB] ? 64'(-w_mag) : 64'(w_mag);
            o_side    <= r_side[NB];
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_step
        logic [64:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_rem[g], r_num[g][NB-1]};
        assign w_ge = w_sh >= {1'b0, r_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_ge ? 64'(w_sh - {1'b0, r_den[g]}) : w_sh[63:0];
                r_num[g+1]  <= {r_num[g][NB-2:0], 1'b0};
                r_quo[g+1]  <= {r_quo[g][NB-2:0], w_ge};
                r_den[g+1]  <= r_den[g];
                r_neg[g+1]  <= r_neg[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign w_mag = (|r_quo[NB][NB-1:63]) ? 64'(SMAX) : {1'b0, r_quo[NB][62:0]};

endmodule

`default_nettype wire

FILE: rtl/rcc_qsqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_qsqrt import rcc_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic signed [63:0]  i_v,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output logic signed [63:0]       o_root,
    output logic [SIDE_W-1:0]        o_side
);

    // one root bit per stage over v << FRAC_BITS
    localparam int NB = 64 + FRAC_BITS;
    localparam int P  = (NB + 1) / 2;
    localparam int NW = 2 * P;

    logic [NW-1:0]      r_num  [P+1];
    logic [P+1:0]       r_rem  [P+1];
    logic [P-1:0]       r_root [P+1];
    logic               r_vld  [P+1];
    logic [SIDE_W-1:0]  r_side [P+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= (i_v > 64'sd0) ? NW'({i_v, {FRAC_BITS{1'b0}}}) : '0;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < P; g++) begin : g_step
        logic [P+1:0] w_rem;
        logic [P+1:0] w_trial;
        logic         w_ge;

        assign w_rem   = {r_rem[g][P-1:0], r_num[g][NW-1:NW-2]};
        assign w_trial = {r_root[g], 2'b01};
        assign w_ge    = w_rem >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_root[g+1] <= {r_root[g][P-2:0], w_ge};
                r_num[g+1]  <= {r_num[g][NW-3:0], 2'b00};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[P];
    assign o_root  = 64'(r_root[P]);
    assign o_side  = r_side[P];

endmodule

`default_nettype wire

FILE: rtl/rcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_front import rcc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_valid,
    input  wire logic [191:0]  i_data,
    output logic               o_ready,
    input  wire logic          i_take,
    output logic               o_valid,
    output t_item              o_item
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt, n_cnt;
    t_item              w_item;
    logic               w_push, w_pop;

    // classify: offsets from the cone frame and the base-plane numerator
    always_comb begin
        w_item.ox      = i_data[31:0];
        w_item.oy      = i_data[63:32];
        w_item.oz      = i_data[95:64];
        w_item.dx      = i_data[127:96];
        w_item.dy      = i_data[159:128];
        w_item.dz      = i_data[191:160];
        w_item.rel_x   = 33'(w_item.ox) - 33'(i_cfg.bx);
        w_item.rel_z   = 33'(w_item.oz) - 33'(i_cfg.bz);
        w_item.rel_y   = 34'(w_item.oy) - 34'(i_cfg.by) - 34'({1'b0, i_cfg.height});
        w_item.base_dy = 33'(i_cfg.by) - 33'(w_item.oy);
        w_item.dy_nz   = w_item.dy != 32'sd0;
    end

    assign o_ready = r_cnt != (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_back import rcc_pkg::*; #(
    parameter int FRAC_BITS  = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    output logic        o_take,
    input  wire logic   i_ready,
    output logic        o_valid,
    output logic        o_hit,
    output logic [30:0] o_dist
);

    localparam logic [63:0] HIT_MAX = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dy;
        logic               dy_nz;
        logic signed [63:0] t3;
    } t_s2;

    typedef struct packed {
        logic signed [63:0] sa, shb, sc;
        logic signed [31:0] oy, dy;
        logic               dy_nz;
        logic signed [63:0] t3;
    } t_s3;

    typedef struct packed {
        logic signed [63:0] a, hb;
        logic signed [31:0] oy, dy;
        logic               base_ok;
        logic signed [63:0] t3;
    } t_s4;

    typedef struct packed {
        logic signed [63:0] a, hb;
        logic signed [31:0] oy, dy;
        logic               base_ok;
        logic signed [63:0] t3;
        logic               side_ok;
    } t_s5;

    typedef struct packed {
        logic signed [31:0] oy, dy;
        logic               base_ok;
        logic signed [63:0] t3;
        logic               side_ok;
    } t_s6;

    typedef struct packed {
        logic signed [31:0] oy;
        logic               base_ok;
        logic signed [63:0] t3;
        logic               side_ok;
        logic signed [63:0] root0, root1;
    } t_s7;

    logic               w_en;
    logic               w_v1, w_v2, w_v3, w_v4, w_v5, w_v6, w_v7;
    t_item              w_s1;
    t_s2                w_s2i, w_s2;
    t_s3                w_s3i, w_s3;
    t_s4                w_s4i, w_s4;
    t_s5                w_s5i, w_s5;
    t_s6                w_s6i, w_s6;
    t_s7                w_s7i, w_s7;
    logic signed [63:0] w_q, w_t3, w_k, w_kdyy, w_hbhb, w_ac, w_disc, w_sq;
    logic signed [63:0] w_a, w_hb, w_c, w_px, w_pz, w_nhb, w_n0, w_n1;
    logic signed [63:0] w_r0, w_r1, w_m0, w_m1, w_yh0, w_yh1, w_by, w_top;
    logic signed [63:0] w_p2a [11];
    logic signed [63:0] w_p2b [11];
    logic signed [63:0] w_p2  [11];
    logic signed [63:0] w_p3a [5];
    logic signed [63:0] w_p3b [5];
    logic signed [63:0] w_p3  [5];
    logic               w_base_ok, w_side_ok, w_c0, w_c1, w_found;
    logic signed [63:0] w_best;
    logic [63:0]        w_cap;
    logic               r_out_valid;

    // whole back end advances together; the output register is its last stage
    assign w_en    = !r_out_valid || i_ready;
    assign o_take  = w_en;
    assign o_valid = r_out_valid;

    // slope ratio and base-plane distance
    rcc_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_item))) u_div_q (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_a(64'(i_cfg.radius)), .i_b(64'(i_cfg.height)), .i_side(i_item),
        .o_valid(w_v1), .o_q(w_q), .o_side(w_s1)
    );

    rcc_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_t3 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_a(64'(i_item.base_dy)), .i_b(64'(i_item.dy)), .i_side(1'b0),
        .o_valid(), .o_q(w_t3), .o_side()
    );

    // first products of the quadratic and of the base hit point
    assign w_s2i = {w_s1.ox, w_s1.oy, w_s1.oz, w_s1.dy, w_s1.dy_nz, w_t3};

    always_comb begin
        w_p2a[0]  = 64'(w_s1.dx);    w_p2b[0]  = 64'(w_s1.dx);
        w_p2a[1]  = 64'(w_s1.dz);    w_p2b[1]  = 64'(w_s1.dz);
        w_p2a[2]  = 64'(w_s1.dy);    w_p2b[2]  = 64'(w_s1.dy);
        w_p2a[3]  = 64'(w_s1.dx);    w_p2b[3]  = 64'(w_s1.rel_x);
        w_p2a[4]  = 64'(w_s1.dz);    w_p2b[4]  = 64'(w_s1.rel_z);
        w_p2a[5]  = 64'(w_s1.dy);    w_p2b[5]  = 64'(w_s1.rel_y);
        w_p2a[6]  = 64'(w_s1.rel_x); w_p2b[6]  = 64'(w_s1.rel_x);
        w_p2a[7]  = 64'(w_s1.rel_z); w_p2b[7]  = 64'(w_s1.rel_z);
        w_p2a[8]  = 64'(w_s1.rel_y); w_p2b[8]  = 64'(w_s1.rel_y);
        w_p2a[9]  = 64'(w_s1.dx);    w_p2b[9]  = w_t3;
        w_p2a[10] = 64'(w_s1.dz);    w_p2b[10] = w_t3;
    end

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s2))) u_mul_k (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v1),
        .i_a(w_q), .i_b(w_q), .i_side(w_s2i),
        .o_valid(w_v2), .o_p(w_k), .o_side(w_s2)
    );

    for (genvar g = 0; g < 11; g++) begin : g_mul2
        rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul (
            .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v1),
            .i_a(w_p2a[g]), .i_b(w_p2b[g]), .i_side(1'b0),
            .o_valid(), .o_p(w_p2[g]), .o_side()
        );
    end

    // scale the y terms by the slope, square the base offsets
    assign w_px  = qsub(qadd(64'(w_s2.ox), w_p2[9]), 64'(i_cfg.bx));
    assign w_pz  = qsub(qadd(64'(w_s2.oz), w_p2[10]), 64'(i_cfg.bz));
    assign w_s3i = {qadd(w_p2[0], w_p2[1]), qadd(w_p2[3], w_p2[4]), qadd(w_p2[6], w_p2[7]),
                    w_s2.oy, w_s2.dy, w_s2.dy_nz, w_s2.t3};

    always_comb begin
        w_p3a[0] = w_k;                w_p3b[0] = w_p2[5];
        w_p3a[1] = w_k;                w_p3b[1] = w_p2[8];
        w_p3a[2] = w_px;               w_p3b[2] = w_px;
        w_p3a[3] = w_pz;               w_p3b[3] = w_pz;
        w_p3a[4] = 64'(i_cfg.radius);  w_p3b[4] = 64'(i_cfg.radius);
    end

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s3))) u_mul_kdyy (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v2),
        .i_a(w_k), .i_b(w_p2[2]), .i_side(w_s3i),
        .o_valid(w_v3), .o_p(w_kdyy), .o_side(w_s3)
    );

    for (genvar g = 0; g < 5; g++) begin : g_mul3
        rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul (
            .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v2),
            .i_a(w_p3a[g]), .i_b(w_p3b[g]), .i_side(1'b0),
            .o_valid(), .o_p(w_p3[g]), .o_side()
        );
    end

    // quadratic coefficients and the base disk decision
    assign w_a       = qsub(w_s3.sa, w_kdyy);
    assign w_hb      = qsub(w_s3.shb, w_p3[0]);
    assign w_c       = qsub(w_s3.sc, w_p3[1]);
    assign w_base_ok = w_s3.dy_nz && (w_s3.t3 > 64'sd0)
                    && (qadd(w_p3[2], w_p3[3]) <= w_p3[4]);
    assign w_s4i     = {w_a, w_hb, w_s3.oy, w_s3.dy, w_base_ok, w_s3.t3};

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s4))) u_mul_hbhb (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v3),
        .i_a(w_hb), .i_b(w_hb), .i_side(w_s4i),
        .o_valid(w_v4), .o_p(w_hbhb), .o_side(w_s4)
    );

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_ac (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v3),
        .i_a(w_a), .i_b(w_c), .i_side(1'b0),
        .o_valid(), .o_p(w_ac), .o_side()
    );

    // discriminant; side is a candidate only for a real, nondegenerate quadratic
    assign w_disc    = qsub(w_hbhb, w_ac);
    assign w_side_ok = (i_cfg.height != '0) && (w_s4.a != 64'sd0) && !w_disc[63];
    assign w_s5i     = {w_s4.a, w_s4.hb, w_s4.oy, w_s4.dy, w_s4.base_ok, w_s4.t3, w_side_ok};

    rcc_qsqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s5))) u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v4),
        .i_v(w_disc), .i_side(w_s5i),
        .o_valid(w_v5), .o_root(w_sq), .o_side(w_s5)
    );

    assign w_nhb = -w_s5.hb;
    assign w_n0  = qadd(w_nhb, w_sq);
    assign w_n1  = qsub(w_nhb, w_sq);
    assign w_s6i = {w_s5.oy, w_s5.dy, w_s5.base_ok, w_s5.t3, w_s5.side_ok};

    rcc_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s6))) u_div_r0 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v5),
        .i_a(w_n0), .i_b(w_s5.a), .i_side(w_s6i),
        .o_valid(w_v6), .o_q(w_r0), .o_side(w_s6)
    );

    rcc_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_r1 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v5),
        .i_a(w_n1), .i_b(w_s5.a), .i_side(1'b0),
        .o_valid(), .o_q(w_r1), .o_side()
    );

    // hit heights of both roots
    assign w_s7i = {w_s6.oy, w_s6.base_ok, w_s6.t3, w_s6.side_ok, w_r0, w_r1};

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_s7))) u_mul_y0 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v6),
        .i_a(64'(w_s6.dy)), .i_b(w_r0), .i_side(w_s7i),
        .o_valid(w_v7), .o_p(w_m0), .o_side(w_s7)
    );

    rcc_qmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_y1 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v6),
        .i_a(64'(w_s6.dy)), .i_b(w_r1), .i_side(1'b0),
        .o_valid(), .o_p(w_m1), .o_side()
    );

    assign w_by  = 64'(i_cfg.by);
    assign w_top = w_by + 64'({1'b0, i_cfg.height});
    assign w_yh0 = qadd(64'(w_s7.oy), w_m0);
    assign w_yh1 = qadd(64'(w_s7.oy), w_m1);
    assign w_c0  = w_s7.side_ok && (w_yh0 >= w_by) && (w_yh0 <= w_top)
                && (w_s7.root0 > 64'sd0);
    assign w_c1  = w_s7.side_ok && (w_yh1 >= w_by) && (w_yh1 <= w_top)
                && (w_s7.root1 > 64'sd0);

    // keep the nearest positive candidate
    always_comb begin
        w_found = 1'b0;
        w_best  = '0;
        if (w_c0) begin
            w_found = 1'b1;
            w_best  = w_s7.root0;
        end
        if (w_c1 && (!w_found || w_s7.root1 < w_best)) begin
            w_found = 1'b1;
            w_best  = w_s7.root1;
        end
        if (w_s7.base_ok && (!w_found || w_s7.t3 < w_best)) begin
            w_found = 1'b1;
            w_best  = w_s7.t3;
        end
    end

    assign w_cap = (64'(w_best) > HIT_MAX) ? HIT_MAX : 64'(w_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit  <= w_found;
            o_dist <= w_found ? w_cap[30:0] : '0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ray_capped_cone_intersection.sv
`timescale 1ns / 1ps
`default_nettype none

// Ray against a capped upright cone, signed fixed point with FRAC_BITS
// fraction bits. Each beat on the slave side carries one ray and yields exactly
// one beat on the master side: a hit flag and the nearest positive ray
// distance (zero on a miss, capped at 2^(DATA_WIDTH-1)-1). One ray is taken
// per clock; the block stalls only while the four-entry input queue is full,
// which it becomes only while the output register holds a beat the sink has
// not taken. An input beat passes in series through the queue, a bit-per-stage
// divider, three pipelined multiplier rows, the bit-per-stage square root, a
// second divider, a fourth multiplier row and the output register. The user
// must write the cone registers (base centre, radius, height) through the
// config port only while no ray is in flight; the block itself does not
// enforce it. Writes to unused indexes are dropped.

module ray_capped_cone_intersection import rcc_pkg::*; #(
    parameter int FRAC_BITS  = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  wire logic [191:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // hit [0], hit_distance [31:1]
    output logic [31:0]        m_axis_tdata
);

    t_cfg        r_cfg;
    logic        w_q_valid, w_take, w_hit;
    t_item       w_item;
    logic [30:0] w_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bx     <= '0;
            r_cfg.by     <= '0;
            r_cfg.bz     <= '0;
            r_cfg.radius <= 31'd65536;
            r_cfg.height <= 31'd65536;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BASE_X: r_cfg.bx     <= i_cfg_data;
                CFG_BASE_Y: r_cfg.by     <= i_cfg_data;
                CFG_BASE_Z: r_cfg.bz     <= i_cfg_data;
                CFG_RADIUS: r_cfg.radius <= i_cfg_data[30:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept rays, compute frame offsets, hold them in the queue
    rcc_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata), .o_ready(s_axis_tready),
        .i_take(w_take), .o_valid(w_q_valid), .o_item(w_item)
    );

    // back: quadratic, square root, roots, cap test, nearest hit
    rcc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(w_q_valid), .i_item(w_item), .o_take(w_take),
        .i_ready(m_axis_tready), .o_valid(m_axis_tvalid),
        .o_hit(w_hit), .o_dist(w_dist)
    );

    assign m_axis_tdata = {w_dist, w_hit};

endmodule

`default_nettype wire

FILE: rtl/rcc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [31:0]   m_axis_tdata
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stall right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == 31'd0)
        else $error("miss beat with nonzero distance");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed under stall");

endmodule

bind ray_capped_cone_intersection rcc_chk u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire
